// File: rtl/hsn_pkg.sv
// Shared constants, types and helpers for the heightmap normal unit.
// No dependencies.
package hsn_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
   localparam int CFG_W     = 11;
   localparam int WW        = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
   localparam int H_W       = 16;
   localparam int SUM_W     = 18;
   localparam int D_W       = 19;
   localparam int COL_W     = 10;

   typedef logic signed [H_W-1:0] height_type;
   typedef logic signed [D_W-1:0] slope_type;

   typedef struct packed {
      logic [15:0] nx;
      logic [14:0] ny;
      logic [15:0] nz;
   } nrm_result_type;

   function automatic logic signed [SUM_W-1:0] sum3(height_type a, height_type b,
                                                    height_type c);
      logic signed [SUM_W-1:0] r;
      r = SUM_W'(a) + (SUM_W'(b) <<< 1) + SUM_W'(c);
      return r;
   endfunction

endpackage

// File: rtl/hsn_line_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hsn_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/hsn_normaliser.sv
// Serial normaliser: squares, long division and digit-by-digit root per component.
// Depends on hsn_pkg.
module hsn_normaliser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hsn_pkg::slope_type     dx,
   input  hsn_pkg::slope_type     dz,
   output logic                   done,
   output hsn_pkg::nrm_result_type result
);

   typedef enum logic [6:0] {
      N_IDLE = 7'b0000001,
      N_MULX = 7'b0000010,
      N_MULZ = 7'b0000100,
      N_LOAD = 7'b0001000,
      N_DIV  = 7'b0010000,
      N_ROOT = 7'b0100000,
      N_FIN  = 7'b1000000
   } nstate_type;

   nstate_type  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  comp_ff, comp_in;
   logic        negx_ff, negz_ff;
   logic [17:0] ax_ff, az_ff;
   logic [35:0] sqx_ff, sqz_ff;
   logic [37:0] s_ff;
   logic [37:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] op_ff, res_ff, one_ff;
   hsn_pkg::nrm_result_type res_out_ff;
   logic        done_ff;

   logic [38:0] r2;
   logic        ge;
   logic [31:0] t;
   logic [16:0] m;
   logic [14:0] mag;

   always_comb begin
      r2  = {rem_ff, 1'b0};
      ge  = r2 >= {1'b0, s_ff};
      t   = res_ff + one_ff;
      m   = ({1'b0, res_ff[15:0]} + 17'd1) >> 1;
      mag = (m > 17'd32767) ? 15'h7FFF : m[14:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      unique case (state_ff)
         N_IDLE: if (start) state_in = N_MULX;
         N_MULX: state_in = N_MULZ;
         N_MULZ: begin
            state_in = N_LOAD;
            comp_in  = 2'd0;
         end
         N_LOAD: begin
            state_in = N_DIV;
            cnt_in   = 5'd0;
         end
         N_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = N_ROOT;
               cnt_in   = 5'd0;
            end
         end
         N_ROOT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) state_in = N_FIN;
         end
         N_FIN: begin
            if (comp_ff == 2'd2) begin
               state_in = N_IDLE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = N_LOAD;
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         done_ff  <= (state_ff == N_FIN) && (comp_ff == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               negx_ff <= dx > 0;
               negz_ff <= dz > 0;
               ax_ff   <= dx[hsn_pkg::D_W-1] ? 18'(-dx) : dx[17:0];
               az_ff   <= dz[hsn_pkg::D_W-1] ? 18'(-dz) : dz[17:0];
            end
         end
         N_MULX: sqx_ff <= ax_ff * ax_ff;
         N_MULZ: begin
            sqz_ff <= az_ff * az_ff;
            s_ff   <= 38'(sqx_ff) + 38'(az_ff * az_ff) + 38'd65536;
         end
         N_LOAD: begin
            unique case (comp_ff)
               2'd0:    rem_ff <= 38'(sqx_ff);
               2'd1:    rem_ff <= 38'd65536;
               default: rem_ff <= 38'(sqz_ff);
            endcase
            quo_ff <= '0;
         end
         N_DIV: begin
            rem_ff <= ge ? 38'(r2 - {1'b0, s_ff}) : r2[37:0];
            quo_ff <= {quo_ff[30:0], ge};
            if (cnt_ff == 5'd31) begin
               op_ff  <= {quo_ff[30:0], ge};
               res_ff <= '0;
               one_ff <= 32'h4000_0000;
            end
         end
         N_ROOT: begin
            if (cnt_ff != 5'd16) begin
               if (op_ff >= t) begin
                  op_ff  <= op_ff - t;
                  res_ff <= (res_ff >> 1) + one_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               one_ff <= one_ff >> 2;
            end
         end
         N_FIN: begin
            unique case (comp_ff)
               2'd0:    res_out_ff.nx <= negx_ff ? 16'(17'h10000 - 17'(mag)) : 16'(mag);
               2'd1:    res_out_ff.ny <= mag;
               default: res_out_ff.nz <= negz_ff ? 16'(17'h10000 - 17'(mag)) : 16'(mag);
            endcase
         end
         default: ;
      endcase
   end

   assign done   = done_ff;
   assign result = res_out_ff;

endmodule

// File: rtl/heightmap_sobel_normals_unit.sv
// Heightmap normal unit: a raster stream of Q8.8 heights in, one Q1.15 unit
// normal out per grid point from 3x3 Sobel slopes; results lag one row.
// Each item is read from the line store and then updated; each result then takes
// a start state, the serial normaliser (two squaring steps, then per component a
// load, a 32-step division, a root and a finish, then the done state) and a push
// state, which lasts longer while the output register is still held; an item
// yields zero, one or two results, and a new item is taken only once idle again.
// The caller closes a grid with one row of flush beats. Depends on hsn_pkg,
// hsn_line_ram and hsn_normaliser.
module heightmap_sobel_normals_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // height
   input  logic        req_tuser,   // command (1 = flush)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // normal_x, normal_y, normal_z, column, zero fill
   output logic        rsp_tlast
);

   typedef enum logic [4:0] {
      T_IDLE  = 5'b00001,
      T_LOAD  = 5'b00010,
      T_START = 5'b00100,
      T_BUSY  = 5'b01000,
      T_PUSH  = 5'b10000
   } tstate_type;

   localparam int AW = hsn_pkg::ADDR_W;
   localparam int WW = hsn_pkg::WW;

   tstate_type state_ff, state_in;
   logic [hsn_pkg::CFG_W-1:0] gw_ff;
   logic [AW-1:0] column_count_ff;
   logic [1:0]    rows_seen_ff;
   hsn_pkg::height_type win_ff [3][2];
   logic [AW-1:0] c_ff;
   logic          lastcol_ff, flush_ff, job_ff, emit2_ff;
   hsn_pkg::height_type h_ff;
   hsn_pkg::slope_type dx1_ff, dz1_ff, dx2_ff, dz2_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [63:0]   rsp_data_ff;

   logic [WW-1:0] gw_ext, w_eff;
   logic [AW-1:0] c_eff;
   logic          accept, out_free;
   logic [31:0]   rd_data;
   hsn_pkg::height_type colc [3];
   hsn_pkg::height_type wz [3][2];
   logic          emit1, emit2;
   logic          norm_start, norm_done;
   hsn_pkg::nrm_result_type norm_res;

   always_comb begin
      gw_ext = WW'(gw_ff);
      if (gw_ext == '0) begin
         w_eff = WW'(1);
      end else if (gw_ext > WW'(hsn_pkg::MAX_WIDTH)) begin
         w_eff = WW'(hsn_pkg::MAX_WIDTH);
      end else begin
         w_eff = gw_ext;
      end
      c_eff = (WW'(column_count_ff) >= w_eff) ? '0 : column_count_ff;
   end

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign norm_start = (state_ff == T_START);

   hsn_line_ram #(.DEPTH(hsn_pkg::MAX_WIDTH), .WIDTH(32)) u_ram (
      .clock   (clock),
      .wr_en   (state_ff == T_LOAD),
      .wr_addr (c_ff),
      .wr_data ({colc[1], h_ff}),
      .rd_en   (accept),
      .rd_addr (c_eff),
      .rd_data (rd_data)
   );

   hsn_normaliser u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .dx     (job_ff ? dx2_ff : dx1_ff),
      .dz     (job_ff ? dz2_ff : dz1_ff),
      .done   (norm_done),
      .result (norm_res)
   );

   always_comb begin
      colc[0] = (rows_seen_ff >= 2'd2) ? rd_data[31:16] : '0;
      colc[1] = (rows_seen_ff >= 2'd1) ? rd_data[15:0] : '0;
      colc[2] = h_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            wz[i][j] = (c_ff == '0) ? '0 : win_ff[i][j];
         end
      end
      emit1 = (c_ff != '0) && (rows_seen_ff != 2'd0);
      emit2 = lastcol_ff && (rows_seen_ff != 2'd0);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (accept) state_in = T_LOAD;
         T_LOAD:  state_in = (emit1 || emit2) ? T_START : T_IDLE;
         T_START: state_in = T_BUSY;
         T_BUSY:  if (norm_done) state_in = T_PUSH;
         T_PUSH: begin
            if (out_free) state_in = (!job_ff && emit2_ff) ? T_START : T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= T_IDLE;
         gw_ff           <= 11'd1024;
         column_count_ff <= '0;
         rows_seen_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         job_ff          <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) win_ff[i][j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            gw_ff           <= csr_wr_data;
            column_count_ff <= '0;
            rows_seen_ff    <= '0;
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 2; j++) win_ff[i][j] <= '0;
            end
         end else if (state_ff == T_LOAD) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= wz[i][1];
               win_ff[i][1] <= colc[i];
            end
            if (lastcol_ff) begin
               column_count_ff <= '0;
               if (flush_ff) begin
                  rows_seen_ff <= 2'd0;
               end else if (rows_seen_ff != 2'd2) begin
                  rows_seen_ff <= rows_seen_ff + 2'd1;
               end
            end else begin
               column_count_ff <= c_ff + AW'(1);
            end
            job_ff <= !emit1;
         end else if (state_ff == T_PUSH && out_free) begin
            job_ff <= 1'b1;
         end
         if (state_ff == T_PUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff       <= c_eff;
         lastcol_ff <= (WW'(c_eff) == w_eff - WW'(1));
         flush_ff   <= req_tuser;
         h_ff       <= req_tuser ? '0 : req_tdata;
      end
      if (state_ff == T_LOAD) begin
         dx1_ff   <= hsn_pkg::D_W'(hsn_pkg::sum3(colc[0], colc[1], colc[2]))
                   - hsn_pkg::D_W'(hsn_pkg::sum3(wz[0][0], wz[1][0], wz[2][0]));
         dz1_ff   <= hsn_pkg::D_W'(hsn_pkg::sum3(wz[2][0], wz[2][1], colc[2]))
                   - hsn_pkg::D_W'(hsn_pkg::sum3(wz[0][0], wz[0][1], colc[0]));
         dx2_ff   <= hsn_pkg::D_W'(0)
                   - hsn_pkg::D_W'(hsn_pkg::sum3(wz[0][1], wz[1][1], wz[2][1]));
         dz2_ff   <= hsn_pkg::D_W'(hsn_pkg::sum3(wz[2][1], colc[2], '0))
                   - hsn_pkg::D_W'(hsn_pkg::sum3(wz[0][1], colc[0], '0));
         emit2_ff <= emit2;
      end
      if (state_ff == T_PUSH && out_free) begin
         rsp_data_ff <= {7'd0,
                         hsn_pkg::COL_W'(job_ff ? c_ff : c_ff - AW'(1)),
                         norm_res.nz, norm_res.ny, norm_res.nx};
         rsp_last_ff <= job_ff || !emit2_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_after_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_LOAD |-> $past(req_tvalid && req_tready))
      else $error("line store update without input beat");
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      norm_done |-> state_ff == T_BUSY)
      else $error("normaliser finished outside busy state");
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_IDLE |-> WW'(column_count_ff) < w_eff)
      else $error("column count beyond grid width");
   a_rows_sat: assert property (@(posedge clock) disable iff (reset)
      rows_seen_ff != 2'd3)
      else $error("rows seen past saturation");
`endif

endmodule
